[rtl/spc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the simple path counter.
// No dependencies; every other file but spc_ram imports this package.
package spc_pkg;

  localparam int ROW_W     = 12;  // adjacency row width
  localparam int VTX_W     = 4;   // vertex index field width
  localparam int CFG_W     = 4;   // configuration register width
  localparam int CFG_IDX_W = 2;   // configuration register index width
  localparam int CNT_W     = 63;  // path count width

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT  = 2'd3;

  localparam logic [CFG_W-1:0] RST_SOURCE  = 4'd0;
  localparam logic [CFG_W-1:0] RST_TARGET  = 4'd1;
  localparam logic [CFG_W-1:0] RST_MAX_LEN = 4'd12;
  localparam logic [CFG_W-1:0] RST_VCOUNT  = 4'd12;

  // controller -> datapath
  typedef struct packed {
    logic load_row;    // store the accepted adjacency row
    logic run_init;    // start of a count: clear mask, index, totals
    logic seed_wr;     // write the single-vertex path at the source
    logic mask_next;   // step to the next mask
    logic entry_rd;    // read table entry (mask, i)
    logic entry_take;  // latch entry, compute neighbors, zero the entry
    logic idx_next;    // step to the next end vertex
    logic edge_rd;     // read table entry (mask | j, j)
    logic edge_upd;    // saturating add and write back
    logic clr_wr;      // post-reset clearing pass
    logic res_load;    // load the result register
  } spc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic degenerate;  // configuration gives a zero count outright
    logic mask_work;   // current mask holds the source, within the limit
    logic mask_last;   // current mask is the full vertex set
    logic i_last;      // current end vertex is the last one in use
    logic nbrs_empty;  // no neighbors left to extend to
    logic clr_last;    // clearing pass is at the last entry
  } spc_stat_t;

endpackage

[rtl/spc_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one adjacency row per beat.
// Depends on spc_pkg.
interface spc_in_if;
  import spc_pkg::*;

  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] row_index;
  logic [ROW_W-1:0] row_bits;
  logic             last_row;

  modport source (output valid, row_index, row_bits, last_row, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

[rtl/spc_out_if.sv]
`timescale 1ns / 1ps
// Result channel: one path count per beat.
// Depends on spc_pkg.
interface spc_out_if;
  import spc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] path_count;
  logic             saturated;

  modport source (output valid, path_count, saturated, input ready);
  modport sink   (input valid, path_count, saturated, output ready);
endinterface

[rtl/simple_path_counter.sv]
`timescale 1ns / 1ps
// Simple path counter top level: sequencer plus datapath.
// Depends on spc_pkg, spc_in_if, spc_out_if, spc_ctrl, spc_dp.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        row_index, row_bits, last_row
//   out_ch   out  valid/ready        path_count, saturated
//   cfg_*    in   cfg_we (no wait)   cfg_index, cfg_wdata
//
// Rows without last_row may stream back to back. A last_row beat starts a
// count: setup, then a walk over the masks; for each mask that holds the
// source within the length limit, each end vertex is read and latched and
// each edge followed is read and updated; then the result is loaded.
// After reset all (2^MAX_VERTICES)*MAX_VERTICES table entries (49152 by
// default) are swept to zero with in_ch.ready low; config writes still land.
// A finished count waits for a free result register, with in_ch.ready low.
module simple_path_counter #(
  parameter int MAX_VERTICES = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  spc_in_if.sink                        in_ch,
  spc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spc_pkg::CFG_W-1:0]     cfg_wdata
);
  import spc_pkg::*;

  spc_cmd_t  cmd;
  spc_stat_t stat;

  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_row),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  spc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .row_index  (in_ch.row_index),
    .row_bits   (in_ch.row_bits),
    .cmd        (cmd),
    .stat       (stat),
    .path_count (out_ch.path_count),
    .saturated  (out_ch.saturated)
  );

endmodule

[rtl/spc_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spc_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 49152
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/spc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the path counter: clearing pass, row loads, mask/vertex/edge walk.
// Depends on spc_pkg; drives spc_dp through spc_cmd_t.
module spc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  spc_pkg::spc_stat_t stat,
  output spc_pkg::spc_cmd_t  cmd
);
  import spc_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_MASK  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_HERE  = 4'd5;
  localparam logic [3:0] S_EDGE  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_row = 1'b1;
          if (in_last) state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.run_init = 1'b1;
        cmd.seed_wr  = !stat.degenerate;
        state_nxt    = stat.degenerate ? S_DONE : S_MASK;
      end
      S_MASK: begin
        if (stat.mask_work) begin
          state_nxt = S_RD;
        end else if (stat.mask_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mask_next = 1'b1;
        end
      end
      S_RD: begin
        cmd.entry_rd = 1'b1;
        state_nxt    = S_HERE;
      end
      S_HERE: begin
        cmd.entry_take = 1'b1;
        state_nxt      = S_EDGE;
      end
      S_EDGE: begin
        if (!stat.nbrs_empty) begin
          cmd.edge_rd = 1'b1;
          state_nxt   = S_UPD;
        end else if (!stat.i_last) begin
          cmd.idx_next = 1'b1;
          state_nxt    = S_RD;
        end else if (stat.mask_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mask_next = 1'b1;
          state_nxt     = S_MASK;
        end
      end
      S_UPD: begin
        cmd.edge_upd = 1'b1;
        state_nxt    = S_EDGE;
      end
      S_DONE: begin
        // hold the finished count until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/spc_dp.sv]
`timescale 1ns / 1ps
// Datapath of the path counter: config registers, adjacency rows, DP table RAM,
// saturating adders and the result register. Depends on spc_pkg and spc_ram.
module spc_dp #(
  parameter int MAX_VERTICES = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [spc_pkg::VTX_W-1:0]     row_index,
  input  logic [spc_pkg::ROW_W-1:0]     row_bits,
  input  spc_pkg::spc_cmd_t             cmd,
  output spc_pkg::spc_stat_t            stat,
  output logic [spc_pkg::CNT_W-1:0]     path_count,
  output logic                          saturated
);
  import spc_pkg::*;

  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int VIW   = $clog2(MAX_VERTICES);
  localparam int NB_W  = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int DEPTH = (2 ** MAX_VERTICES) * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [NW-1:0] popcount(input logic [MAX_VERTICES-1:0] v);
    logic [NW-1:0] c;
    c = '0;
    for (int b = 0; b < MAX_VERTICES; b++) begin
      c = c + NW'(v[b]);
    end
    return c;
  endfunction

  function automatic logic [VIW-1:0] lowest(input logic [NB_W-1:0] v);
    logic [VIW-1:0] r;
    r = '0;
    for (int b = NB_W - 1; b >= 0; b--) begin
      if (v[b]) r = VIW'(b);
    end
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0] src_r, tgt_r, lim_r, vcnt_r;

  // graph and walk state
  logic [ROW_W-1:0]        adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] mask_r;
  logic [AW-1:0]           base_r;      // mask_r * MAX_VERTICES
  logic [VIW-1:0]          i_r;
  logic [VIW-1:0]          j_r;
  logic [NB_W-1:0]         nbrs_r;
  logic [CNT_W-1:0]        here_r;
  logic [AW-1:0]           edge_addr_r;
  logic [CNT_W-1:0]        ans_r;
  logic                    flag_r;
  logic [AW-1:0]           clr_r;
  logic [CNT_W-1:0]        path_count_r;
  logic                    sat_r;

  logic [NW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] full;
  logic [VIW-1:0]          src_idx;
  logic [NW-1:0]           pc;
  logic                    proc;
  logic [NB_W-1:0]         nbrs_new;
  logic [VIW-1:0]          j_sel;
  logic [AW-1:0]           ent_addr, edge_addr, seed_addr;
  logic [CNT_W-1:0]        rd_data;
  logic [CNT_W:0]          tbl_sum, ans_sum;
  logic                    tbl_sat, ans_sat, is_tgt;
  logic [CNT_W-1:0]        tbl_new, ans_new;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [CNT_W-1:0]        ram_wdata;

  assign n_eff   = (32'(vcnt_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcnt_r);
  assign full    = ~({MAX_VERTICES{1'b1}} << n_eff);
  assign src_idx = VIW'(src_r);
  assign pc      = popcount(mask_r);
  assign proc    = 32'(pc) < 32'(lim_r);

  assign nbrs_new = adj_r[i_r][NB_W-1:0] & full[NB_W-1:0] & ~mask_r[NB_W-1:0];
  assign j_sel    = lowest(nbrs_r);

  // row of mask | (1 << j) starts MAX_VERTICES << j entries above the current one
  assign ent_addr  = base_r + AW'(i_r);
  assign edge_addr = base_r + (AW'(MAX_VERTICES) << j_sel) + AW'(j_sel);
  assign seed_addr = (AW'(MAX_VERTICES) << src_idx) + AW'(src_idx);

  // stored values never exceed COUNT_MAX, so one extra bit holds the sum; a sum at or above COUNT_MAX saturates
  assign tbl_sum = {1'b0, rd_data} + {1'b0, here_r};
  assign tbl_sat = tbl_sum >= {1'b0, COUNT_MAX};
  assign tbl_new = tbl_sat ? COUNT_MAX : tbl_sum[CNT_W-1:0];
  assign ans_sum = {1'b0, ans_r} + {1'b0, here_r};
  assign ans_sat = ans_sum >= {1'b0, COUNT_MAX};
  assign ans_new = ans_sat ? COUNT_MAX : ans_sum[CNT_W-1:0];
  assign is_tgt  = 32'(j_r) == 32'(tgt_r);

  assign stat.degenerate = (n_eff == '0) || (32'(src_r) >= 32'(n_eff)) ||
                           (32'(tgt_r) >= 32'(n_eff)) || (src_r == tgt_r) ||
                           (32'(lim_r) < 2);
  assign stat.mask_work  = mask_r[src_idx] && (32'(pc) <= 32'(lim_r));
  assign stat.mask_last  = (mask_r == full);
  assign stat.i_last     = (32'(i_r) + 32'd1) == 32'(n_eff);
  assign stat.nbrs_empty = (nbrs_r == '0);
  assign stat.clr_last   = (clr_r == AW'(DEPTH - 1));

  // Every entry read with entry_rd is zeroed right after, and rows at the
  // length limit are zeroed too, so the table is all zero again at the end.
  always_comb begin
    ram_we    = cmd.clr_wr || cmd.seed_wr || cmd.entry_take || cmd.edge_upd;
    ram_waddr = edge_addr_r;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_waddr = clr_r;
    end else if (cmd.seed_wr) begin
      ram_waddr = seed_addr;
      ram_wdata = CNT_W'(1);
    end else if (cmd.entry_take) begin
      ram_waddr = ent_addr;
    end else if (cmd.edge_upd) begin
      ram_wdata = tbl_new;
    end
  end

  spc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.entry_rd || cmd.edge_rd),
    .raddr (cmd.entry_rd ? ent_addr : edge_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= RST_SOURCE;
      tgt_r  <= RST_TARGET;
      lim_r  <= RST_MAX_LEN;
      vcnt_r <= RST_VCOUNT;
      clr_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE:  src_r  <= cfg_wdata;
          CFG_TARGET:  tgt_r  <= cfg_wdata;
          CFG_MAX_LEN: lim_r  <= cfg_wdata;
          CFG_VCOUNT:  vcnt_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && (32'(row_index) < MAX_VERTICES)) begin
      adj_r[VIW'(row_index)] <= row_bits;
    end
    if (cmd.run_init) begin
      mask_r <= '0;
      base_r <= '0;
      i_r    <= '0;
      ans_r  <= '0;
      flag_r <= 1'b0;
    end else if (cmd.mask_next) begin
      mask_r <= mask_r + MAX_VERTICES'(1);
      base_r <= base_r + AW'(MAX_VERTICES);
      i_r    <= '0;
    end else if (cmd.idx_next) begin
      i_r <= i_r + VIW'(1);
    end
    if (cmd.entry_take) begin
      here_r <= rd_data;
      nbrs_r <= (proc && (rd_data != '0)) ? nbrs_new : '0;
    end else if (cmd.edge_rd) begin
      j_r         <= j_sel;
      nbrs_r      <= nbrs_r & ~(NB_W'(1) << j_sel);
      edge_addr_r <= edge_addr;
    end
    if (cmd.edge_upd) begin
      // either adder clamping marks the count as saturated
      flag_r <= flag_r || tbl_sat || (is_tgt && ans_sat);
      if (is_tgt) begin
        ans_r <= ans_new;
      end
    end
    if (cmd.res_load) begin
      path_count_r <= ans_r;
      sat_r        <= flag_r;
    end
  end

  assign path_count = path_count_r;
  assign saturated  = sat_r;

  a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.edge_upd |-> $past(cmd.edge_rd))
    else $error("table update without a preceding edge read");

  a_take_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.entry_take |-> $past(cmd.entry_rd))
    else $error("entry latched without a preceding read");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.seed_wr, cmd.entry_take, cmd.edge_upd}))
    else $error("more than one table write source");

  a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.entry_rd |-> ((mask_r & ~full) == '0))
    else $error("mask walk passed the vertex set");

  a_clamp_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load && (ans_r == COUNT_MAX)) |-> flag_r)
    else $error("clamped count without saturation flag");

endmodule
